// File: hw/rtl/iir_df2_pkg.sv
// ----------------------------------------------------------------------------
// iir_df2_pkg
// Shared types and fixed-point constants of the Direct Form II IIR filter.
// ----------------------------------------------------------------------------
`default_nettype none

package iir_df2_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int COEF_W    = 24;
  localparam int DL_W      = 32;
  localparam int PROD_W    = COEF_W + DL_W;
  localparam int ACC_W     = 60;
  localparam int NUM_REGS  = 7;
  localparam int CFG_IDX_W = 3;

  localparam int X_SHIFT = 29;
  localparam int W_SHIFT = 20;
  localparam int Y_SHIFT = 29;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_B0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_B1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_A1 = 3'd4;

  localparam logic [COEF_W-1:0] B0_RESET = 24'h100000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_WUPD,
    ST_BMUL,
    ST_BACC,
    ST_OUT
  } iir_df2_state_e;

  typedef struct packed {
    logic load;
    logic mac;
    logic wupd;
    logic bmul;
    logic yout;
  } iir_df2_cmd_t;

endpackage

`default_nettype wire

// File: hw/rtl/iir_direct_form_two_filter_core.sv
// ----------------------------------------------------------------------------
// iir_direct_form_two_filter_core
// Direct Form II IIR filter, order ORDER (1 to 3), streaming in and out.
// ----------------------------------------------------------------------------
// One item is processed at a time: the single shared 24x32 multiplier takes
// one feedback and one feedforward product per tap, then b0*w, with rounding
// and saturation on w and on y. The result sits in an output register, so a
// new item is taken while it waits; the block only stalls if a second result
// is ready before the first is taken. Coefficients are Q4.20, samples Q1.15,
// the delay line Q8.24; reset clears the delay line and loads b0 = 1.0, all
// else 0.
`default_nettype none

module iir_direct_form_two_filter_core #(
  parameter int ORDER = 3
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire [iir_df2_pkg::SAMPLE_W-1:0]     s_axis_tdata,   // [15:0] sample_in
  input  wire                                 s_axis_tlast,   // end_of_block
  output logic                                m_axis_tvalid,
  input  wire                                 m_axis_tready,
  output logic [iir_df2_pkg::SAMPLE_W-1:0]    m_axis_tdata,   // [15:0] filtered_out
  output logic                                m_axis_tlast,   // block_last
  input  wire                                 cfg_we_i,
  input  wire [iir_df2_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire [iir_df2_pkg::COEF_W-1:0]       cfg_data_i
);
  import iir_df2_pkg::*;

  localparam int CNT_W = (2 * ORDER > 1) ? $clog2(2 * ORDER) : 1;

  iir_df2_cmd_t              cmd;
  logic [CNT_W-1:0]          mac_idx;
  logic signed [SAMPLE_W-1:0] filtered;

  iir_df2_ctrl #(
    .ORDER(ORDER)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd),
    .mac_idx_o   (mac_idx)
  );

  iir_df2_dp #(
    .ORDER(ORDER)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .mac_idx_i  (mac_idx),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .sample_i   ($signed(s_axis_tdata)),
    .last_i     (s_axis_tlast),
    .filtered_o (filtered),
    .last_o     (m_axis_tlast)
  );

  assign m_axis_tdata = filtered;

endmodule

`default_nettype wire

// File: hw/rtl/iir_df2_ctrl.sv
// ----------------------------------------------------------------------------
// iir_df2_ctrl
// Sequencer: steps the shared multiplier through the taps and runs the
// output handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module iir_df2_ctrl #(
  parameter int ORDER = 3
) (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       in_valid_i,
  output logic                      in_ready_o,
  output logic                      out_valid_o,
  input  wire                       out_ready_i,
  output iir_df2_pkg::iir_df2_cmd_t cmd_o,
  output logic [((2*ORDER > 1) ? $clog2(2*ORDER) : 1)-1:0] mac_idx_o
);
  import iir_df2_pkg::*;

  localparam int STEPS = 2 * ORDER;
  localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

  iir_df2_state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = ST_MAC;
        end
      end
      ST_MAC: begin
        cmd_o.mac = 1'b1;
        cnt_d     = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(STEPS - 1)) begin
          cnt_d   = '0;
          state_d = ST_WUPD;
        end
      end
      ST_WUPD: begin
        cmd_o.wupd = 1'b1;
        state_d    = ST_BMUL;
      end
      ST_BMUL: begin
        cmd_o.bmul = 1'b1;
        state_d    = ST_BACC;
      end
      ST_BACC: begin
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.yout  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign mac_idx_o   = cnt_q;

endmodule

`default_nettype wire

// File: hw/rtl/iir_df2_dp.sv
// ----------------------------------------------------------------------------
// iir_df2_dp
// Datapath: coefficient registers, delay line, one shared 24x32 multiplier,
// two accumulators, rounding and saturation, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module iir_df2_dp #(
  parameter int ORDER = 3
) (
  input  wire                                       clk_i,
  input  wire                                       rst_ni,
  input  iir_df2_pkg::iir_df2_cmd_t                 cmd_i,
  input  wire [((2*ORDER > 1) ? $clog2(2*ORDER) : 1)-1:0] mac_idx_i,
  input  wire                                       cfg_we_i,
  input  wire [iir_df2_pkg::CFG_IDX_W-1:0]          cfg_idx_i,
  input  wire [iir_df2_pkg::COEF_W-1:0]             cfg_data_i,
  input  wire signed [iir_df2_pkg::SAMPLE_W-1:0]    sample_i,
  input  wire                                       last_i,
  output logic signed [iir_df2_pkg::SAMPLE_W-1:0]   filtered_o,
  output logic                                      last_o
);
  import iir_df2_pkg::*;

  localparam int CNT_W = (2 * ORDER > 1) ? $clog2(2 * ORDER) : 1;
  localparam int TAP_W = (ORDER > 1) ? $clog2(ORDER) : 1;

  logic [COEF_W-1:0]        coef_q [NUM_REGS];
  logic signed [DL_W-1:0]   dl_q   [ORDER];

  logic [TAP_W-1:0]         tap;
  logic [CFG_IDX_W-1:0]     coef_sel;
  logic signed [COEF_W-1:0] coef_op;
  logic signed [DL_W-1:0]   data_op;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic                     prod_vld_q;
  logic                     prod_sub_q;

  logic signed [ACC_W-1:0]  wacc_q, yacc_q;
  logic signed [ACC_W-1:0]  wsum, wsh, ysum, ysh;
  logic signed [DL_W-1:0]   w_sat;
  logic signed [SAMPLE_W-1:0] y_sat;
  logic                     w_ovf, y_ovf;

  logic                     last_in_q;
  logic signed [SAMPLE_W-1:0] filtered_q;
  logic                     last_q;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        coef_q[i] <= '0;
      end
      coef_q[REG_B0] <= B0_RESET;
    end else if (cfg_we_i && (cfg_idx_i < CFG_IDX_W'(NUM_REGS))) begin
      coef_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  // operand selection: even steps feedback, odd steps feedforward
  always_comb begin
    tap      = TAP_W'(mac_idx_i >> 1);
    coef_sel = mac_idx_i[0] ? (REG_B1 + CFG_IDX_W'(tap)) : (REG_A1 + CFG_IDX_W'(tap));
    if (cmd_i.bmul) begin
      coef_op = coef_q[REG_B0];
      data_op = dl_q[0];
    end else begin
      coef_op = coef_q[coef_sel];
      data_op = dl_q[tap];
    end
    prod_d = coef_op * data_op;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
    end else begin
      prod_vld_q <= cmd_i.mac || cmd_i.bmul;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q     <= prod_d;
    prod_sub_q <= cmd_i.mac && !mac_idx_i[0];
  end

  // accumulators
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      wacc_q    <= ACC_W'(sample_i) <<< X_SHIFT;
      yacc_q    <= '0;
      last_in_q <= last_i;
    end else if (prod_vld_q) begin
      if (prod_sub_q) begin
        wacc_q <= wacc_q - ACC_W'(prod_q);
      end else begin
        yacc_q <= yacc_q + ACC_W'(prod_q);
      end
    end
  end

  // w: round half up, saturate to delay-line range
  always_comb begin
    wsum  = wacc_q + (ACC_W'(1) <<< (W_SHIFT - 1));
    wsh   = wsum >>> W_SHIFT;
    w_ovf = !((&wsh[ACC_W-1:DL_W-1]) || !(|wsh[ACC_W-1:DL_W-1]));
    if (w_ovf) begin
      w_sat = wsh[ACC_W-1] ? {1'b1, {(DL_W-1){1'b0}}} : {1'b0, {(DL_W-1){1'b1}}};
    end else begin
      w_sat = wsh[DL_W-1:0];
    end
  end

  // y: round half up, saturate to 16 bits
  always_comb begin
    ysum  = yacc_q + (ACC_W'(1) <<< (Y_SHIFT - 1));
    ysh   = ysum >>> Y_SHIFT;
    y_ovf = !((&ysh[ACC_W-1:SAMPLE_W-1]) || !(|ysh[ACC_W-1:SAMPLE_W-1]));
    if (y_ovf) begin
      y_sat = ysh[ACC_W-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else begin
      y_sat = ysh[SAMPLE_W-1:0];
    end
  end

  // delay line
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ORDER; i++) begin
        dl_q[i] <= '0;
      end
    end else if (cmd_i.wupd) begin
      for (int i = ORDER - 1; i >= 1; i--) begin
        dl_q[i] <= dl_q[i-1];
      end
      dl_q[0] <= w_sat;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.yout) begin
      filtered_q <= y_sat;
      last_q     <= last_in_q;
    end
  end

  assign filtered_o = filtered_q;
  assign last_o     = last_q;

endmodule

`default_nettype wire

// File: hw/rtl/iir_df2_checker.sv
// ----------------------------------------------------------------------------
// iir_df2_sva
// Port-level checks of the filter core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module iir_df2_sva (
  input wire                                clk_i,
  input wire                                rst_ni,
  input wire                                s_axis_tvalid,
  input wire                                s_axis_tready,
  input wire [iir_df2_pkg::SAMPLE_W-1:0]    s_axis_tdata,
  input wire                                s_axis_tlast,
  input wire                                m_axis_tvalid,
  input wire                                m_axis_tready,
  input wire [iir_df2_pkg::SAMPLE_W-1:0]    m_axis_tdata,
  input wire                                m_axis_tlast
);

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // one item in flight: no new item right after acceptance
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while an item is in flight");

  // a new result only comes out of a running item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result appeared with no item in flight");

  // no result the cycle after an item is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> !m_axis_tvalid)
    else $error("result appeared too early");

endmodule

bind iir_direct_form_two_filter_core iir_df2_sva u_iir_df2_sva (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

// File: test/iir_df2_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// iir_df2_checker
// Watches the coefficient port and both streams of the IIR filter core, keeps
// its own copy of the coefficients and delay line, works out each filtered
// sample when an item is taken and compares it with the output items in order.
// ----------------------------------------------------------------------------

module iir_df2_checker
  import iir_df2_pkg::*;
#(
  parameter int ORDER = 3
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  s_axis_tvalid,
  input  wire                  s_axis_tready,
  input  wire [SAMPLE_W-1:0]   s_axis_tdata,   // [15:0] sample_in
  input  wire                  s_axis_tlast,   // end_of_block
  input  wire                  m_axis_tvalid,
  input  wire                  m_axis_tready,
  input  wire [SAMPLE_W-1:0]   m_axis_tdata,   // [15:0] filtered_out
  input  wire                  m_axis_tlast,   // block_last
  input  wire                  cfg_we_i,
  input  wire [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire [COEF_W-1:0]     cfg_data_i,
  output int                   mismatch_count_o,
  output int                   in_flight_o
);

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                last;
  } filter_result_t;

  localparam int     NUM_FF  = int'(REG_A1);
  localparam int     NUM_FB  = NUM_REGS - NUM_FF;
  localparam longint DL_MAX  = (longint'(1) <<< (DL_W - 1)) - 1;
  localparam longint DL_MIN  = -(longint'(1) <<< (DL_W - 1));
  localparam longint OUT_MAX = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
  localparam longint OUT_MIN = -(longint'(1) <<< (SAMPLE_W - 1));

  logic signed [COEF_W-1:0] feedforward_q [0:NUM_FF-1];
  logic signed [COEF_W-1:0] feedback_q    [1:NUM_FB];
  logic signed [DL_W-1:0]   delay_q       [0:ORDER-1];
  filter_result_t           expected_outputs [$];
  filter_result_t           want;

  // one filter step: updates the delay line, returns the output item
  function automatic filter_result_t filter_sample(input logic [SAMPLE_W-1:0] sample,
                                                   input logic last);
    longint         w_acc;
    longint         y_acc;
    longint         w_val;
    longint         y_val;
    filter_result_t res;
    w_acc = longint'($signed(sample)) <<< X_SHIFT;
    y_acc = 0;
    for (int k = 1; k <= ORDER; k++) begin
      w_acc -= longint'(feedback_q[k]) * longint'(delay_q[k-1]);
      y_acc += longint'(feedforward_q[k]) * longint'(delay_q[k-1]);
    end
    w_val = (w_acc + (longint'(1) <<< (W_SHIFT - 1))) >>> W_SHIFT;
    if (w_val > DL_MAX) begin
      w_val = DL_MAX;
    end else if (w_val < DL_MIN) begin
      w_val = DL_MIN;
    end
    y_acc += longint'(feedforward_q[0]) * w_val;
    y_val = (y_acc + (longint'(1) <<< (Y_SHIFT - 1))) >>> Y_SHIFT;
    if (y_val > OUT_MAX) begin
      y_val = OUT_MAX;
    end else if (y_val < OUT_MIN) begin
      y_val = OUT_MIN;
    end
    for (int k = ORDER - 1; k >= 1; k--) begin
      delay_q[k] = delay_q[k-1];
    end
    delay_q[0] = w_val[DL_W-1:0];
    res.sample = y_val[SAMPLE_W-1:0];
    res.last   = last;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (feedforward_q[i]) feedforward_q[i] = '0;
      foreach (feedback_q[i]) feedback_q[i] = '0;
      foreach (delay_q[i]) delay_q[i] = '0;
      feedforward_q[REG_B0] = B0_RESET;
      expected_outputs.delete();
      mismatch_count_o = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i < REG_A1) begin
          feedforward_q[cfg_idx_i] = cfg_data_i;
        end else if (cfg_idx_i < NUM_REGS) begin
          feedback_q[cfg_idx_i - REG_A1 + 1] = cfg_data_i;
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        expected_outputs.push_back(filter_sample(s_axis_tdata, s_axis_tlast));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_outputs.size() == 0) begin
          mismatch_count_o++;
          $display("%0t: output item not expected: expected none, got %h/%b",
                   $time, m_axis_tdata, m_axis_tlast);
        end else begin
          want = expected_outputs.pop_front();
          if (m_axis_tdata !== want.sample) begin
            mismatch_count_o++;
            $display("%0t: filtered_out expected %h, got %h",
                     $time, want.sample, m_axis_tdata);
          end
          if (m_axis_tlast !== want.last) begin
            mismatch_count_o++;
            $display("%0t: block_last expected %b, got %b",
                     $time, want.last, m_axis_tlast);
          end
        end
      end
    end
    in_flight_o = expected_outputs.size();
  end

endmodule

// File: test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the Direct Form II IIR filter core: directed samples at the
// extremes and under saturation, then phases of random samples under random,
// gentle, extreme and reset coefficient sets, with random gaps and stalls on
// both streams and two long output stalls. The checker judges every item.
// ----------------------------------------------------------------------------

module tb;
  import iir_df2_pkg::*;

  localparam int ORDER         = 3;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int LONG_HOLD     = 300;
  localparam int PHASE_ITEMS   = 250;
  localparam int NUM_PHASES    = 8;
  localparam int SETTLE_CYCLES = 2 * ORDER + 5 + 8;
  localparam int COEF_ONE      = 1 << 20;

  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam logic [COEF_W-1:0]   COEF_MAX   = {1'b0, {(COEF_W-1){1'b1}}};
  localparam logic [COEF_W-1:0]   COEF_MIN   = {1'b1, {(COEF_W-1){1'b0}}};

  typedef enum int {
    CF_FULL,
    CF_GENTLE,
    CF_EXTREME,
    CF_RESET
  } coeff_mix_e;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [SAMPLE_W-1:0]  s_axis_tdata  = '0;
  logic                 s_axis_tlast  = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [SAMPLE_W-1:0]  m_axis_tdata;
  logic                 m_axis_tlast;
  logic                 cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i     = '0;
  logic [COEF_W-1:0]    cfg_data_i    = '0;

  int                   mismatch_count;
  int                   in_flight;
  int                   cycle_count   = 0;
  int                   results_taken = 0;
  bit                   tx_quiet      = 1'b0;
  bit                   rx_quiet      = 1'b0;
  logic [COEF_W-1:0]    coef_set [0:NUM_REGS];

  iir_direct_form_two_filter_core #(
    .ORDER(ORDER)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  iir_df2_checker #(
    .ORDER(ORDER)
  ) checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .s_axis_tlast    (s_axis_tlast),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .m_axis_tlast    (m_axis_tlast),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .mismatch_count_o(mismatch_count),
    .in_flight_o     (in_flight)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // called at a clock edge; returns at the edge the item is taken
  task automatic send_sample(input logic [SAMPLE_W-1:0] sample, input logic last);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= sample;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if ($urandom_range(0, 31) == 0) tx_quiet = !tx_quiet;
  endtask

  task automatic drain_filter();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (in_flight != 0) @(posedge clk_i);
  endtask

  // writes every register plus one index past the end
  task automatic load_coeffs();
    for (int i = 0; i <= NUM_REGS; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= CFG_IDX_W'(i);
      cfg_data_i <= coef_set[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic pick_coeffs(input coeff_mix_e mix);
    int r;
    int span;
    for (int i = 0; i <= NUM_REGS; i++) begin
      case (mix)
        CF_FULL: begin
          coef_set[i] = COEF_W'($urandom);
        end
        CF_GENTLE: begin
          // small feedback keeps the filter roughly stable
          span = (i < int'(REG_A1)) ? COEF_ONE : COEF_ONE / 4;
          r = int'($urandom_range(0, 2 * span)) - span;
          coef_set[i] = r[COEF_W-1:0];
        end
        CF_EXTREME: begin
          coef_set[i] = $urandom_range(0, 1) ? COEF_MAX : COEF_MIN;
        end
        default: begin
          coef_set[i] = (i == int'(REG_B0)) ? B0_RESET : '0;
        end
      endcase
    end
  endtask

  function automatic logic [SAMPLE_W-1:0] random_sample();
    int r;
    case ($urandom_range(0, 3))
      0: begin
        r = int'($urandom_range(0, 1024)) - 512;
        return r[SAMPLE_W-1:0];
      end
      1: return $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // output side: random stalls, two long hold-offs to back the core up
  initial begin
    int hold;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (results_taken == 400 || results_taken == 1410) begin
        hold = LONG_HOLD;
      end else begin
        hold = rx_quiet ? 0 : $urandom_range(0, 6);
      end
      if (hold != 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      results_taken++;
      if ($urandom_range(0, 31) == 0) rx_quiet = !rx_quiet;
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb NOT OK");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset coefficients pass the input straight through
    send_sample('0, 1'b0);
    send_sample(SAMPLE_MAX, 1'b1);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(16'h0001, 1'b0);
    send_sample(16'hffff, 1'b1);
    send_sample(16'h5555, 1'b0);
    send_sample(16'haaaa, 1'b1);
    drain_filter();

    // full gain with positive feedback: w and output saturate high
    pick_coeffs(CF_RESET);
    for (int i = 0; i < NUM_REGS; i++) begin
      coef_set[i] = (i < int'(REG_A1)) ? COEF_MAX : COEF_MIN;
    end
    coef_set[NUM_REGS] = COEF_W'($urandom);
    load_coeffs();
    repeat (4) send_sample(SAMPLE_MAX, 1'b0);
    repeat (4) send_sample(SAMPLE_MIN, 1'b1);
    repeat (2) send_sample('0, 1'b0);
    drain_filter();

    // negative gain, feedback of opposite sign
    for (int i = 0; i < NUM_REGS; i++) begin
      coef_set[i] = (i < int'(REG_A1)) ? COEF_MIN : COEF_MAX;
    end
    load_coeffs();
    repeat (3) send_sample(SAMPLE_MAX, 1'b1);
    repeat (3) send_sample(SAMPLE_MIN, 1'b0);
    drain_filter();

    for (int p = 0; p < NUM_PHASES; p++) begin
      pick_coeffs(coeff_mix_e'(p % 4));
      load_coeffs();
      repeat (PHASE_ITEMS) send_sample(random_sample(), 1'($urandom_range(0, 1)));
      drain_filter();
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && in_flight == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
